// File: hdl/ild_pkg.sv
// Package: shared constants, opcodes and types for the linked deque core.
package ild_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int WORD_W = 32;
    localparam int POS_W = 8;
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_INSERT     = 3'd5,
        OP_REMOVE     = 3'd6,
        OP_CLEAR      = 3'd7
    } t_opcode;
endpackage

// File: hdl/ild_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface ild_req_if;
    import ild_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] data_in;
    modport source (output valid, opcode, position, data_in, input ready);
    modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

interface ild_rsp_if #(parameter int CNT_W = 9);
    import ild_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     success;
    logic signed [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]         count;
    modport source (output valid, success, data_out, count, input ready);
    modport sink   (input valid, success, data_out, count, output ready);
endinterface

// File: hdl/ild_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module ild_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/indexed_linked_deque_core.sv
// Top level: linked deque with node memories and an operation sequencer.
// Read, remove and middle inserts walk position hops from the head (pop back starts at the
// tail) through the node memory read port. One request in flight at a time; the next beat
// is accepted in the cycle after the response beat at the earliest.
// Reset: head, tail, length, free chain and bump mark cleared at once; node memories are not.
module indexed_linked_deque_core
    import ild_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW  = $clog2(CAPACITY),
    parameter int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ild_req_if.sink          req,
    ild_rsp_if.source        rsp
);
    localparam int NW = AW + 1; // node index with null marker
    localparam logic [NW-1:0] NIL = NW'(CAPACITY);
    // position and count compared at a width that holds both
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FREEQ = 8'b0000_0010, // read next of free head
        S_FREEW = 8'b0000_0100,
        S_WALK  = 8'b0000_1000, // issue read of current node
        S_WALKW = 8'b0001_0000, // wait for read data
        S_EXEC  = 8'b0010_0000, // perform write sequence
        S_LINK  = 8'b0100_0000, // second link write
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [NW-1:0]    r_head, r_tail, r_free, r_mark;
    logic [CNT_W-1:0] r_count;
    t_opcode          r_op;
    logic [POS_W-1:0] r_pos;
    logic [WORD_W-1:0] r_din;
    logic [POS_W:0]   r_step;
    logic [NW-1:0]    r_cur, r_newn;
    logic [NW-1:0]    r_cfwd, r_cback;
    logic [WORD_W-1:0] r_cword;
    logic             r_ok;
    logic [WORD_W-1:0] r_dout;
    logic             r_rvalid;

    // memories
    logic we_w, we_f, we_b;
    logic [AW-1:0] wa_w, wa_f, wa_b, ra;
    logic [WORD_W-1:0] wd_w, rd_w;
    logic [NW-1:0] wd_f, wd_b, rd_f, rd_b;

    ild_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_words (
        .i_clk, .i_we(we_w), .i_waddr(wa_w), .i_wdata(wd_w), .i_raddr(ra), .o_rdata(rd_w));
    ild_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_fwd (
        .i_clk, .i_we(we_f), .i_waddr(wa_f), .i_wdata(wd_f), .i_raddr(ra), .o_rdata(rd_f));
    ild_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_back (
        .i_clk, .i_we(we_b), .i_waddr(wa_b), .i_wdata(wd_b), .i_raddr(ra), .o_rdata(rd_b));

    logic acc;
    assign req.ready = (r_state == S_IDLE);
    assign acc = req.valid && req.ready;
    assign rsp.valid    = r_rvalid;
    assign rsp.success  = r_ok;
    assign rsp.data_out = r_dout;
    assign rsp.count    = r_count;

    logic [CMP_W-1:0] pos_ext, cnt_ext;
    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    logic need_node, is_push_f, is_push_b, is_mid, is_unlink;
    // classification of the held request
    always_comb begin
        is_push_f = (r_op == OP_PUSH_FRONT) || (r_op == OP_INSERT && r_pos == '0);
        is_push_b = (r_op == OP_PUSH_BACK) ||
                    (r_op == OP_INSERT && r_pos != '0 && pos_ext == cnt_ext);
        is_mid    = (r_op == OP_INSERT && r_pos != '0 && pos_ext < cnt_ext);
        is_unlink = (r_op == OP_POP_FRONT) || (r_op == OP_POP_BACK) ||
                    (r_op == OP_REMOVE);
        need_node = is_push_f || is_push_b || is_mid;
    end

    logic have_node;
    assign have_node = (r_free != NIL) || (r_mark < NIL);

    always_comb begin
        we_w = 1'b0; wa_w = r_newn[AW-1:0]; wd_w = r_din;
        we_f = 1'b0; wa_f = r_newn[AW-1:0]; wd_f = NIL;
        we_b = 1'b0; wa_b = r_newn[AW-1:0]; wd_b = NIL;
        ra   = r_cur[AW-1:0];
        if (r_state == S_FREEQ) begin
            ra = r_free[AW-1:0];
        end
        if (r_state == S_EXEC) begin
            if (need_node) begin
                we_w = 1'b1;
                we_f = 1'b1; we_b = 1'b1;
                if (is_push_f) begin
                    wd_b = NIL; wd_f = r_head;
                end else if (is_push_b) begin
                    wd_f = NIL; wd_b = r_tail;
                end else begin
                    wd_f = r_cur; wd_b = r_cback;
                end
            end else if (is_unlink) begin
                // fix forward link of predecessor and back link of successor; a head node is put on free chain
                we_f = 1'b1;
                if (r_cback != NIL) begin
                    wa_f = r_cback[AW-1:0]; wd_f = r_cfwd;
                end else begin
                    wa_f = r_cur[AW-1:0]; wd_f = r_free;
                end
                if (r_cfwd != NIL) begin
                    we_b = 1'b1; wa_b = r_cfwd[AW-1:0]; wd_b = r_cback;
                end
            end
        end
        if (r_state == S_LINK) begin
            if (is_push_f) begin
                we_b = (r_head != NIL); wa_b = r_head[AW-1:0]; wd_b = r_newn;
            end else if (is_push_b) begin
                we_f = (r_tail != NIL); wa_f = r_tail[AW-1:0]; wd_f = r_newn;
            end else if (is_mid) begin
                we_f = 1'b1; wa_f = r_cback[AW-1:0]; wd_f = r_newn;
                we_b = 1'b1; wa_b = r_cur[AW-1:0];  wd_b = r_newn;
            end else begin
                // unlinked node joins free chain
                we_f = 1'b1; wa_f = r_cur[AW-1:0]; wd_f = r_free;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc) n_state = S_FREEQ;
            S_FREEQ: n_state = S_FREEW;
            S_FREEW: begin
                if (r_op == OP_CLEAR) n_state = S_RESP;
                else if ((r_op == OP_POP_FRONT || r_op == OP_POP_BACK) && r_count == '0)
                    n_state = S_RESP;
                else if ((r_op == OP_READ || r_op == OP_REMOVE) && pos_ext >= cnt_ext)
                    n_state = S_RESP;
                else if (r_op == OP_INSERT && pos_ext > cnt_ext) n_state = S_RESP;
                else if (need_node && !have_node) n_state = S_RESP;
                else if (is_unlink || r_op == OP_READ || is_mid) n_state = S_WALK;
                else n_state = S_EXEC;
            end
            S_WALK:  n_state = S_WALKW;
            S_WALKW: n_state = (r_step == '0) ? S_EXEC : S_WALK;
            S_EXEC: begin
                if (r_op == OP_READ) n_state = S_RESP;
                else if (is_unlink && r_cback == NIL) n_state = S_LINK;
                else n_state = S_LINK;
            end
            S_LINK:  n_state = S_RESP;
            S_RESP:  if (rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_free   <= NIL;
            r_mark   <= '0;
            r_count  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESP && rsp.ready) r_rvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_op  <= t_opcode'(req.opcode);
                        r_pos <= req.position;
                        r_din <= req.data_in;
                        r_ok  <= 1'b0;
                        r_dout <= '0;
                    end
                end
                S_FREEW: begin
                    // rd_f holds next of free head
                    if (r_free != NIL) r_newn <= r_free;
                    else r_newn <= r_mark;
                    if (r_op == OP_CLEAR) begin
                        r_head <= NIL; r_tail <= NIL; r_free <= NIL;
                        r_mark <= '0; r_count <= '0; r_ok <= 1'b1;
                    end
                    if (r_op == OP_POP_BACK) begin
                        r_cur <= r_tail; r_step <= '0;
                    end else begin
                        r_cur  <= r_head;
                        r_step <= (r_op == OP_POP_FRONT) ? '0 : {1'b0, r_pos};
                    end
                    if (need_node && have_node && n_state != S_RESP) begin
                        if (r_free != NIL) r_free <= rd_f;
                        else r_mark <= r_mark + 1'b1;
                    end
                end
                S_WALKW: begin
                    r_cfwd  <= rd_f;
                    r_cback <= rd_b;
                    r_cword <= rd_w;
                    if (r_step != '0) begin
                        r_cur  <= rd_f;
                        r_step <= r_step - 1'b1;
                    end
                end
                S_EXEC: begin
                    r_ok <= 1'b1;
                    if (r_op == OP_READ) r_dout <= r_cword;
                    if (is_unlink) begin
                        r_dout <= r_cword;
                        if (r_cback == NIL) r_head <= r_cfwd;
                        if (r_cfwd == NIL) r_tail <= r_cback;
                        r_count <= r_count - 1'b1;
                    end
                end
                S_LINK: begin
                    if (is_push_f) begin
                        if (r_head == NIL) r_tail <= r_newn;
                        r_head <= r_newn;
                    end else if (is_push_b) begin
                        if (r_tail == NIL) r_head <= r_newn;
                        r_tail <= r_newn;
                    end
                    if (need_node) r_count <= r_count + 1'b1;
                    if (is_unlink) r_free <= r_cur;
                end
                default: ;
            endcase
            if (n_state == S_RESP && r_state != S_RESP) r_rvalid <= 1'b1;
        end
    end

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> r_state == S_RESP)
        else $error("response outside response state");

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NIL && r_tail == NIL))
        else $error("empty list with live ends");
endmodule
